FILE: hdl/ptg_pkg.sv
// ----------------------------------------------------------------------------
// ptg_pkg
// Shared constants for the square-wave tone generator.
// ----------------------------------------------------------------------------
package ptg_pkg;

	// timer tick rate and ticks per millisecond
	localparam int TIMER_HZ     = 1000000;
	localparam int TICKS_PER_MS = 1000;

	// frequency, duration and wave counter width
	localparam int DATA_W = 16;
	// width of the tick-in-millisecond counter
	localparam int TICK_W = 10;
	// width of the dividend and quotient
	localparam int DIV_W  = $clog2(TIMER_HZ + 1);
	// width wide enough to test the quotient against the 16-bit ceiling
	localparam int EXT_W  = (DIV_W > DATA_W) ? DIV_W : DATA_W + 1;
	// width of the divider step counter
	localparam int STEP_W = $clog2(DIV_W);

	// dividend as a vector
	localparam logic [DIV_W-1:0] TIMER_HZ_V = DIV_W'(TIMER_HZ);

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_NOTE = 1'b1;

endpackage

FILE: hdl/ptg_div.sv
// ----------------------------------------------------------------------------
// ptg_div
// Restoring divider of the timer rate by a frequency, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ptg_div
	import ptg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W:0]   rem_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DATA_W-1:0] dsr_q;
	logic              done_q;

	// shifted partial remainder and trial subtraction
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W+1:0] diff;
	logic              fits;

	assign rem_sh = {rem_q[DATA_W-1:0], dvd_q[DIV_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign fits   = !diff[DATA_W+1];

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			// one-cycle pulse after the last quotient bit
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= TIMER_HZ_V;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W:0] : rem_sh;
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: hdl/pwm_tone_generator.sv
// ----------------------------------------------------------------------------
// pwm_tone_generator
// Square-wave tone generator advanced by timer tick items.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item per transfer:
//   kind 0 is one timer tick, kind 1 starts a note of the given frequency
//   and duration in milliseconds (frequency 0 is a rest).
//   Each item gives exactly one result on the output channel
//   (out_valid/out_ready): wave_level, busy_res and done_res.
//   A tick or a rest is registered into the output at its transfer, and ticks
//   and rests can be taken one per cycle while the receiver keeps up.
//   A tone needs 1000000/frequency, done by a restoring divider that yields
//   one quotient bit a cycle; its result is loaded through the ST_DIV and
//   ST_FIN states once the divider is done, and the block is not ready
//   meanwhile, so the next item waits until the tone's result is loaded.
//   The result sits in an output register; a new item is taken while it
//   waits only if it is being taken in the same cycle, so a stalled
//   receiver holds back the input channel.
//   Reset stops the wave, clears all counters and empties the output.
// ----------------------------------------------------------------------------
module pwm_tone_generator
	import ptg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [DATA_W-1:0] frequency,
	input  logic [DATA_W-1:0] note_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              wave_level,
	output logic              busy_res,
	output logic              done_res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [DATA_W-1:0] limit_q;
	logic [DATA_W-1:0] cmp_q;
	logic [DATA_W-1:0] count_q;
	logic              run_q;
	logic [DATA_W-1:0] ms_q;
	logic [TICK_W-1:0] tick_q;
	logic              out_valid_q;
	logic              level_q;
	logic              busy_q;
	logic              done_q;

	logic              in_xfer;
	logic              out_free;
	logic              div_start;
	logic              div_done;
	logic              res_load;
	logic [DIV_W-1:0]  quot;

	// limit from quotient, saturated to 16 bits
	logic [EXT_W-1:0]  q_ext;
	logic [EXT_W-1:0]  lim_ext;
	logic [DATA_W-1:0] lim;

	// tick path
	logic [TICK_W:0]   tick_inc;
	logic              ms_wrap;
	logic [DATA_W-1:0] ms_dec;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_xfer   = in_valid && in_ready;
	assign div_start = in_xfer && (kind == KIND_NOTE) && (frequency != '0);

	// a result is loaded for ticks and rests at once, for tones at the end
	assign res_load  = (in_xfer && !div_start) || ((state_q == ST_FIN) && out_free);

	ptg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (frequency),
		.done     (div_done),
		.quotient (quot)
	);

	assign q_ext   = EXT_W'(quot);
	assign lim_ext = (q_ext == '0) ? '0 : q_ext - 1'b1;
	assign lim     = (lim_ext > EXT_W'({DATA_W{1'b1}})) ? {DATA_W{1'b1}}
	                                                   : lim_ext[DATA_W-1:0];

	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign ms_wrap  = tick_inc >= (TICK_W + 1)'(TICKS_PER_MS);
	assign ms_dec   = ms_q - 1'b1;

	// sequencer, wave state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= '0;
			cmp_q       <= '0;
			count_q     <= '0;
			run_q       <= 1'b0;
			ms_q        <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			level_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (kind == KIND_NOTE) begin
							ms_q   <= note_ms;
							tick_q <= '0;
							if (frequency == '0) begin
								// rest: stop and clear the wave counter
								run_q   <= 1'b0;
								count_q <= '0;
								level_q <= 1'b0;
								busy_q  <= note_ms != '0;
								done_q  <= 1'b0;
							end else begin
								state_q <= ST_DIV;
							end
						end else begin
							// tick: level from the count before it moves
							level_q <= run_q && (count_q < cmp_q);
							if (run_q) begin
								count_q <= (count_q >= limit_q) ? '0 : count_q + 1'b1;
							end
							if (ms_q != '0) begin
								if (ms_wrap) begin
									tick_q <= '0;
									ms_q   <= ms_dec;
									busy_q <= ms_dec != '0;
									done_q <= ms_dec == '0;
								end else begin
									tick_q <= tick_inc[TICK_W-1:0];
									busy_q <= 1'b1;
									done_q <= 1'b0;
								end
							end else begin
								busy_q <= 1'b0;
								done_q <= 1'b0;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						limit_q <= lim;
						cmp_q   <= lim >> 1;
						count_q <= '0;
						run_q   <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// tone result once the output register is free
					if (out_free) begin
						level_q <= cmp_q != '0;
						busy_q  <= ms_q != '0;
						done_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign wave_level = level_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;

endmodule
